[src/isstore_pkg.sv]
// ----------------------------------------------------------------------------
// isstore_pkg
// Shared types, codes and the control program of the indexed sequence store.
// ----------------------------------------------------------------------------
package isstore_pkg;

  localparam int CMD_W    = 3;
  localparam int POS_W    = 7;
  localparam int SYM_W    = 3;
  localparam int PER_W    = 7;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 7;
  localparam int STEP_W   = 5;

  localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_KTH    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd5;

  localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_INDEX  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL       = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_BAD_PERIOD = 2'd3;

  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_EMIT     = 5'd0;
  localparam step_t STEP_WAIT     = 5'd1;
  localparam step_t STEP_DISPATCH = 5'd2;
  localparam step_t STEP_INS_INIT = 5'd3;
  localparam step_t STEP_INS_LOOP = 5'd4;
  localparam step_t STEP_INS_DRN  = 5'd5;
  localparam step_t STEP_INS_PUT  = 5'd6;
  localparam step_t STEP_DEL_INIT = 5'd7;
  localparam step_t STEP_DEL_LOOP = 5'd8;
  localparam step_t STEP_DEL_DRN  = 5'd9;
  localparam step_t STEP_DEL_FIN  = 5'd10;
  localparam step_t STEP_KTH_INIT = 5'd11;
  localparam step_t STEP_KTH_LOOP = 5'd12;
  localparam step_t STEP_KTH_DRN  = 5'd13;
  localparam step_t STEP_KTH_FIN  = 5'd14;
  localparam step_t STEP_RD_ISSUE = 5'd15;
  localparam step_t STEP_RD_TAKE  = 5'd16;
  localparam step_t STEP_CLEAR    = 5'd17;

  typedef enum logic [3:0] {
    U_NOP,
    U_WAIT,
    U_DISPATCH,
    U_INS_INIT,
    U_INS_LOOP,
    U_INS_PUT,
    U_DEL_INIT,
    U_DEL_LOOP,
    U_DEL_FIN,
    U_KTH_INIT,
    U_KTH_LOOP,
    U_KTH_FIN,
    U_RD_ISSUE,
    U_RD_TAKE,
    U_CLEAR,
    U_EMIT
  } uop_t;

  typedef enum logic [2:0] {
    J_NEXT,
    J_ALWAYS,
    J_NO_ACCEPT,
    J_OUT_BUSY,
    J_MORE_UP,
    J_MORE_FWD,
    J_DISPATCH
  } jmp_t;

  typedef enum logic [2:0] {
    R_EMIT,
    R_INSERT,
    R_DELETE,
    R_KTH,
    R_READ,
    R_CLEAR
  } route_t;

  typedef struct packed {
    uop_t  uop;
    jmp_t  jmp;
    step_t target;
  } ctrl_word_t;

  typedef struct packed {
    logic   accept;
    logic   out_busy;
    logic   more_up;
    logic   more_fwd;
    route_t route;
  } dp_flags_t;

  function automatic ctrl_word_t program_word(input step_t step);
    ctrl_word_t w;
    w = '{uop: U_NOP, jmp: J_ALWAYS, target: STEP_WAIT};
    case (step)
      STEP_EMIT:     w = '{uop: U_EMIT,     jmp: J_OUT_BUSY,  target: STEP_EMIT};
      STEP_WAIT:     w = '{uop: U_WAIT,     jmp: J_NO_ACCEPT, target: STEP_WAIT};
      STEP_DISPATCH: w = '{uop: U_DISPATCH, jmp: J_DISPATCH,  target: STEP_EMIT};
      STEP_INS_INIT: w = '{uop: U_INS_INIT, jmp: J_NEXT,      target: STEP_EMIT};
      STEP_INS_LOOP: w = '{uop: U_INS_LOOP, jmp: J_MORE_UP,   target: STEP_INS_LOOP};
      STEP_INS_DRN:  w = '{uop: U_NOP,      jmp: J_NEXT,      target: STEP_EMIT};
      STEP_INS_PUT:  w = '{uop: U_INS_PUT,  jmp: J_ALWAYS,    target: STEP_EMIT};
      STEP_DEL_INIT: w = '{uop: U_DEL_INIT, jmp: J_NEXT,      target: STEP_EMIT};
      STEP_DEL_LOOP: w = '{uop: U_DEL_LOOP, jmp: J_MORE_FWD,  target: STEP_DEL_LOOP};
      STEP_DEL_DRN:  w = '{uop: U_NOP,      jmp: J_NEXT,      target: STEP_EMIT};
      STEP_DEL_FIN:  w = '{uop: U_DEL_FIN,  jmp: J_ALWAYS,    target: STEP_EMIT};
      STEP_KTH_INIT: w = '{uop: U_KTH_INIT, jmp: J_NEXT,      target: STEP_EMIT};
      STEP_KTH_LOOP: w = '{uop: U_KTH_LOOP, jmp: J_MORE_FWD,  target: STEP_KTH_LOOP};
      STEP_KTH_DRN:  w = '{uop: U_NOP,      jmp: J_NEXT,      target: STEP_EMIT};
      STEP_KTH_FIN:  w = '{uop: U_KTH_FIN,  jmp: J_ALWAYS,    target: STEP_EMIT};
      STEP_RD_ISSUE: w = '{uop: U_RD_ISSUE, jmp: J_NEXT,      target: STEP_EMIT};
      STEP_RD_TAKE:  w = '{uop: U_RD_TAKE,  jmp: J_ALWAYS,    target: STEP_EMIT};
      STEP_CLEAR:    w = '{uop: U_CLEAR,    jmp: J_ALWAYS,    target: STEP_EMIT};
      default:       w = '{uop: U_NOP,      jmp: J_ALWAYS,    target: STEP_WAIT};
    endcase
    return w;
  endfunction

  function automatic step_t route_target(input route_t route);
    step_t t;
    t = STEP_EMIT;
    case (route)
      R_INSERT: t = STEP_INS_INIT;
      R_DELETE: t = STEP_DEL_INIT;
      R_KTH:    t = STEP_KTH_INIT;
      R_READ:   t = STEP_RD_ISSUE;
      R_CLEAR:  t = STEP_CLEAR;
      default:  t = STEP_EMIT;
    endcase
    return t;
  endfunction

endpackage

[src/isstore_req_if.sv]
// ----------------------------------------------------------------------------
// isstore_req_if
// Command channel: one item carries a command and its operands.
// ----------------------------------------------------------------------------
interface isstore_req_if;
  logic                             valid;
  logic                             ready;
  logic [isstore_pkg::CMD_W-1:0]    command;
  logic [isstore_pkg::POS_W-1:0]    position;
  logic [isstore_pkg::SYM_W-1:0]    symbol;
  logic [isstore_pkg::PER_W-1:0]    period;

  modport source (output valid, command, position, symbol, period, input ready);
  modport sink   (input valid, command, position, symbol, period, output ready);
endinterface

[src/isstore_rsp_if.sv]
// ----------------------------------------------------------------------------
// isstore_rsp_if
// Result channel: one item per command with status, read value and length.
// ----------------------------------------------------------------------------
interface isstore_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [isstore_pkg::STATUS_W-1:0] status;
  logic [isstore_pkg::SYM_W-1:0]    read_symbol;
  logic [isstore_pkg::LEN_W-1:0]    length;

  modport source (output valid, status, read_symbol, length, input ready);
  modport sink   (input valid, status, read_symbol, length, output ready);
endinterface

[src/isstore_mem.sv]
// ----------------------------------------------------------------------------
// isstore_mem
// Element store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module isstore_mem #(
  parameter int DEPTH = 64
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [$clog2(DEPTH)-1:0]            waddr,
  input  logic [isstore_pkg::SYM_W-1:0]       wdata,
  input  logic [$clog2(DEPTH)-1:0]            raddr,
  output logic [isstore_pkg::SYM_W-1:0]       rdata
);

  logic [isstore_pkg::SYM_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/isstore_seq.sv]
// ----------------------------------------------------------------------------
// isstore_seq
// Microprogram sequencer: step counter, control ROM and jump selection.
// ----------------------------------------------------------------------------
module isstore_seq (
  input  logic                    clk,
  input  logic                    rst,
  input  isstore_pkg::dp_flags_t  flags,
  output isstore_pkg::ctrl_word_t cw
);

  isstore_pkg::step_t step;
  isstore_pkg::step_t step_next;
  isstore_pkg::step_t step_inc;

  assign step_inc = step + isstore_pkg::step_t'(1);

  always_comb begin
    cw = isstore_pkg::program_word(step);
  end

  always_comb begin
    step_next = step_inc;
    case (cw.jmp)
      isstore_pkg::J_NEXT:      step_next = step_inc;
      isstore_pkg::J_ALWAYS:    step_next = cw.target;
      isstore_pkg::J_NO_ACCEPT: step_next = flags.accept   ? step_inc : cw.target;
      isstore_pkg::J_OUT_BUSY:  step_next = flags.out_busy ? cw.target : step_inc;
      isstore_pkg::J_MORE_UP:   step_next = flags.more_up  ? cw.target : step_inc;
      isstore_pkg::J_MORE_FWD:  step_next = flags.more_fwd ? cw.target : step_inc;
      isstore_pkg::J_DISPATCH:  step_next = isstore_pkg::route_target(flags.route);
      default:                  step_next = isstore_pkg::STEP_WAIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= isstore_pkg::STEP_WAIT;
    end else begin
      step <= step_next;
    end
  end

endmodule

[src/isstore_dp.sv]
// ----------------------------------------------------------------------------
// isstore_dp
// Datapath: operand and pointer registers, element store, result register.
// ----------------------------------------------------------------------------
module isstore_dp #(
  parameter int CAPACITY = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  isstore_pkg::ctrl_word_t cw,
  output isstore_pkg::dp_flags_t  flags,
  isstore_req_if.sink             request,
  isstore_rsp_if.source           response
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > isstore_pkg::POS_W) ? CW : isstore_pkg::POS_W;

  logic [isstore_pkg::CMD_W-1:0]    cmd_r;
  logic [isstore_pkg::POS_W-1:0]    pos_r;
  logic [isstore_pkg::SYM_W-1:0]    sym_r;
  logic [isstore_pkg::PER_W-1:0]    per_r;
  logic [CW-1:0]                    count;
  logic [CW-1:0]                    ins_at;
  logic [CW-1:0]                    src;
  logic [CW-1:0]                    dst;
  logic [isstore_pkg::PER_W-1:0]    phase;
  logic                             pv;
  logic                             pv_next;
  logic [AW-1:0]                    pd;
  logic [isstore_pkg::STATUS_W-1:0] status;
  logic [isstore_pkg::SYM_W-1:0]    rdsym;
  logic                             ovalid;
  logic [isstore_pkg::STATUS_W-1:0] res_status;
  logic [isstore_pkg::SYM_W-1:0]    res_symbol;
  logic [isstore_pkg::LEN_W-1:0]    res_length;

  logic [XW-1:0]                    count_x;
  logic [XW-1:0]                    pos_x;
  logic [XW-1:0]                    per_x;
  logic                             full;
  logic [CW-1:0]                    src_dec;
  logic [CW-1:0]                    src_inc;
  logic [isstore_pkg::PER_W-1:0]    phase_inc;
  logic                             accept;
  logic                             out_busy;
  logic                             more_up;
  logic                             more_fwd;
  isstore_pkg::route_t              route;
  logic [isstore_pkg::STATUS_W-1:0] route_status;

  logic                             mem_we;
  logic [AW-1:0]                    mem_waddr;
  logic [isstore_pkg::SYM_W-1:0]    mem_wdata;
  logic [AW-1:0]                    mem_raddr;
  logic [isstore_pkg::SYM_W-1:0]    mem_rdata;

  assign count_x   = XW'(count);
  assign pos_x     = XW'(pos_r);
  assign per_x     = XW'(per_r);
  assign full      = count_x >= XW'(CAPACITY);
  assign src_dec   = src - CW'(1);
  assign src_inc   = src + CW'(1);
  assign phase_inc = phase + isstore_pkg::PER_W'(1);
  assign more_up   = src != ins_at;
  assign more_fwd  = src < count;
  assign accept    = request.valid && request.ready;
  assign out_busy  = ovalid && !response.ready;

  assign request.ready        = !rst && (cw.uop == isstore_pkg::U_WAIT);
  assign response.valid       = ovalid;
  assign response.status      = res_status;
  assign response.read_symbol = res_symbol;
  assign response.length      = res_length;

  assign flags = '{accept: accept, out_busy: out_busy, more_up: more_up,
                   more_fwd: more_fwd, route: route};

  always_comb begin
    route        = isstore_pkg::R_EMIT;
    route_status = isstore_pkg::STATUS_OK;
    case (cmd_r)
      isstore_pkg::CMD_APPEND: begin
        if (full) begin
          route_status = isstore_pkg::STATUS_FULL;
        end else begin
          route = isstore_pkg::R_INSERT;
        end
      end
      isstore_pkg::CMD_INSERT: begin
        if (pos_x > count_x) begin
          route_status = isstore_pkg::STATUS_BAD_INDEX;
        end else if (full) begin
          route_status = isstore_pkg::STATUS_FULL;
        end else begin
          route = isstore_pkg::R_INSERT;
        end
      end
      isstore_pkg::CMD_DELETE: begin
        if (pos_x >= count_x) begin
          route_status = isstore_pkg::STATUS_BAD_INDEX;
        end else begin
          route = isstore_pkg::R_DELETE;
        end
      end
      isstore_pkg::CMD_KTH: begin
        if (per_x == '0 || per_x > count_x) begin
          route_status = isstore_pkg::STATUS_BAD_PERIOD;
        end else begin
          route = isstore_pkg::R_KTH;
        end
      end
      isstore_pkg::CMD_READ: begin
        if (pos_x >= count_x) begin
          route_status = isstore_pkg::STATUS_BAD_INDEX;
        end else begin
          route = isstore_pkg::R_READ;
        end
      end
      isstore_pkg::CMD_CLEAR: begin
        route = isstore_pkg::R_CLEAR;
      end
      default: begin
        route = isstore_pkg::R_EMIT;
      end
    endcase
  end

  always_comb begin
    case (cw.uop)
      isstore_pkg::U_INS_LOOP: mem_raddr = src_dec[AW-1:0];
      isstore_pkg::U_RD_ISSUE: mem_raddr = ins_at[AW-1:0];
      default:                 mem_raddr = src[AW-1:0];
    endcase
  end

  always_comb begin
    case (cw.uop)
      isstore_pkg::U_INS_LOOP: pv_next = more_up;
      isstore_pkg::U_DEL_LOOP: pv_next = more_fwd;
      isstore_pkg::U_KTH_LOOP: pv_next = more_fwd && (phase_inc != per_r);
      default:                 pv_next = 1'b0;
    endcase
  end

  // A moved element is written in the cycle after its read, while the next read
  // is already issued.
  assign mem_we    = pv || (cw.uop == isstore_pkg::U_INS_PUT);
  assign mem_waddr = pv ? pd : ins_at[AW-1:0];
  assign mem_wdata = pv ? mem_rdata : sym_r;

  isstore_mem #(
    .DEPTH (CAPACITY)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      pv     <= 1'b0;
      ovalid <= 1'b0;
    end else begin
      pv <= pv_next;
      if (cw.uop == isstore_pkg::U_EMIT && !out_busy) begin
        ovalid <= 1'b1;
      end else if (ovalid && response.ready) begin
        ovalid <= 1'b0;
      end
      case (cw.uop)
        isstore_pkg::U_WAIT: begin
          if (accept) begin
            cmd_r <= request.command;
            pos_r <= request.position;
            sym_r <= request.symbol;
            per_r <= request.period;
          end
        end
        isstore_pkg::U_DISPATCH: begin
          status <= route_status;
          rdsym  <= '0;
          if (cmd_r == isstore_pkg::CMD_APPEND) begin
            ins_at <= count;
          end else begin
            ins_at <= pos_x[CW-1:0];
          end
        end
        isstore_pkg::U_INS_INIT: begin
          src <= count;
        end
        isstore_pkg::U_INS_LOOP: begin
          if (more_up) begin
            pd  <= src[AW-1:0];
            src <= src_dec;
          end
        end
        isstore_pkg::U_INS_PUT: begin
          count <= count + CW'(1);
        end
        isstore_pkg::U_DEL_INIT: begin
          src <= ins_at + CW'(1);
        end
        isstore_pkg::U_DEL_LOOP: begin
          if (more_fwd) begin
            pd  <= src_dec[AW-1:0];
            src <= src_inc;
          end
        end
        isstore_pkg::U_DEL_FIN: begin
          count <= count - CW'(1);
        end
        isstore_pkg::U_KTH_INIT: begin
          src   <= '0;
          dst   <= '0;
          phase <= '0;
        end
        isstore_pkg::U_KTH_LOOP: begin
          if (more_fwd) begin
            src <= src_inc;
            if (phase_inc == per_r) begin
              phase <= '0;
            end else begin
              phase <= phase_inc;
              pd    <= dst[AW-1:0];
              dst   <= dst + CW'(1);
            end
          end
        end
        isstore_pkg::U_KTH_FIN: begin
          count <= dst;
        end
        isstore_pkg::U_RD_TAKE: begin
          rdsym <= mem_rdata;
        end
        isstore_pkg::U_CLEAR: begin
          count <= '0;
        end
        isstore_pkg::U_EMIT: begin
          if (!out_busy) begin
            res_status <= status;
            res_symbol <= rdsym;
            res_length <= count_x[isstore_pkg::LEN_W-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

[src/indexed_sequence_store_top.sv]
// ----------------------------------------------------------------------------
// indexed_sequence_store_top
// Ordered store of small symbols with append, insert, delete, delete every
// k-th, read and clear commands, run by a microprogrammed sequencer.
// ----------------------------------------------------------------------------
// Each command item yields exactly one result item, and the block takes one
// command at a time. An insert or a delete moves elements one by one: insert
// at position p moves length - p elements and delete at p moves length - p - 1.
// Delete every k-th steps through every stored element. The element store
// reads one entry and writes one entry per cycle while a microcode loop steps
// through the elements. The block is ready for the next command in the same
// cycle in which the result becomes valid. A finished result sits in an output
// register, so the sequencer only waits on the result side when the previous
// result has not been taken yet.
// ----------------------------------------------------------------------------
module indexed_sequence_store_top #(
  parameter int CAPACITY = 64
) (
  input  logic          clk,
  input  logic          rst,
  isstore_req_if.sink   request,
  isstore_rsp_if.source response
);

  isstore_pkg::ctrl_word_t cw;
  isstore_pkg::dp_flags_t  flags;

  isstore_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .cw    (cw)
  );

  isstore_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cw       (cw),
    .flags    (flags),
    .request  (request),
    .response (response)
  );

endmodule
